@@ sv/bte_pkg.sv @@
// ----------------------------------------------------------------------------
// bte_pkg
// Shared types, codes and keyword table for the token expander.
// ----------------------------------------------------------------------------
`default_nettype none

package bte_pkg;

  localparam int KW_TEXT_CHARS = 16;
  localparam int KW_ENTRIES    = 178;
  localparam int KW_LEN_W      = 5;

  localparam logic [7:0] REM_TOKEN = 8'h8f;
  localparam logic [7:0] PREFIX_CE = 8'hce;
  localparam logic [7:0] PREFIX_FE = 8'hfe;
  localparam logic [7:0] TOP_BIT   = 8'h80;
  localparam logic [7:0] LOW_SEVEN = 8'h7f;
  localparam logic [7:0] QUOTE     = 8'h22;

  // Table layout: single tokens, then the CE page, then the FE page.
  localparam logic [7:0] CE_BASE   = 8'd128;
  localparam logic [7:0] FE_BASE   = 8'd139;
  localparam logic [7:0] CE_COUNT  = 8'd11;
  localparam logic [7:0] FE_COUNT  = 8'd39;
  localparam logic [7:0] EMPTY_IDX = 8'd127;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_REMARK = 2'd2;

  typedef struct packed {
    logic [KW_LEN_W-1:0]        len;   // full keyword length
    logic [KW_TEXT_CHARS*8-1:0] text;  // right-justified, first char highest
  } kw_entry_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    else if (c >= 8'hc1 && c <= 8'hda) r = c & LOW_SEVEN;
    return r;
  endfunction

  function automatic kw_entry_t mk(input logic [KW_TEXT_CHARS*8-1:0] s,
                                   input int n);
    kw_entry_t e;
    e.text = s;
    e.len  = KW_LEN_W'(n);
    return e;
  endfunction

  function automatic kw_entry_t kw_lookup(input logic [7:0] idx);
    kw_entry_t e;
    e = mk('0, 0);
    case (idx)
      8'd0: e = mk("end", 3);       8'd1: e = mk("for", 3);
      8'd2: e = mk("next", 4);      8'd3: e = mk("data", 4);
      8'd4: e = mk("input#", 6);    8'd5: e = mk("input", 5);
      8'd6: e = mk("dim", 3);       8'd7: e = mk("read", 4);
      8'd8: e = mk("let", 3);       8'd9: e = mk("goto", 4);
      8'd10: e = mk("run", 3);      8'd11: e = mk("if", 2);
      8'd12: e = mk("restore", 7);  8'd13: e = mk("gosub", 5);
      8'd14: e = mk("return", 6);   8'd15: e = mk("rem", 3);
      8'd16: e = mk("stop", 4);     8'd17: e = mk("on", 2);
      8'd18: e = mk("wait", 4);     8'd19: e = mk("load", 4);
      8'd20: e = mk("save", 4);     8'd21: e = mk("verify", 6);
      8'd22: e = mk("def", 3);      8'd23: e = mk("poke", 4);
      8'd24: e = mk("print#", 6);   8'd25: e = mk("print", 5);
      8'd26: e = mk("cont", 4);     8'd27: e = mk("list", 4);
      8'd28: e = mk("clr", 3);      8'd29: e = mk("cmd", 3);
      8'd30: e = mk("sys", 3);      8'd31: e = mk("open", 4);
      8'd32: e = mk("close", 5);    8'd33: e = mk("get", 3);
      8'd34: e = mk("new", 3);      8'd35: e = mk("tab(", 4);
      8'd36: e = mk("to", 2);       8'd37: e = mk("fn", 2);
      8'd38: e = mk("spc(", 4);     8'd39: e = mk("then", 4);
      8'd40: e = mk("not", 3);      8'd41: e = mk("step", 4);
      8'd42: e = mk("+", 1);        8'd43: e = mk("-", 1);
      8'd44: e = mk("*", 1);        8'd45: e = mk("/", 1);
      8'd46: e = mk("^", 1);        8'd47: e = mk("and", 3);
      8'd48: e = mk("or", 2);       8'd49: e = mk(">", 1);
      8'd50: e = mk("=", 1);        8'd51: e = mk("<", 1);
      8'd52: e = mk("sgn", 3);      8'd53: e = mk("int", 3);
      8'd54: e = mk("abs", 3);      8'd55: e = mk("usr", 3);
      8'd56: e = mk("fre", 3);      8'd57: e = mk("pos", 3);
      8'd58: e = mk("sqr", 3);      8'd59: e = mk("rnd", 3);
      8'd60: e = mk("log", 3);      8'd61: e = mk("exp", 3);
      8'd62: e = mk("cos", 3);      8'd63: e = mk("sin", 3);
      8'd64: e = mk("tan", 3);      8'd65: e = mk("atn", 3);
      8'd66: e = mk("peek", 4);     8'd67: e = mk("len", 3);
      8'd68: e = mk("str$", 4);     8'd69: e = mk("val", 3);
      8'd70: e = mk("asc", 3);      8'd71: e = mk("chr$", 4);
      8'd72: e = mk("left$", 5);    8'd73: e = mk("right$", 6);
      8'd74: e = mk("mid$", 4);     8'd75: e = mk("go", 2);
      8'd76: e = mk("rgr", 3);      8'd77: e = mk("rclr", 4);
      8'd79: e = mk("joy", 3);
      8'd80: e = mk("rdot", 4);     8'd81: e = mk("dec", 3);
      8'd82: e = mk("hex$", 4);     8'd83: e = mk("err$", 4);
      8'd84: e = mk("instr", 5);    8'd85: e = mk("else", 4);
      8'd86: e = mk("resume", 6);   8'd87: e = mk("trap", 4);
      8'd88: e = mk("tron", 4);     8'd89: e = mk("troff", 5);
      8'd90: e = mk("sound", 5);    8'd91: e = mk("vol", 3);
      8'd92: e = mk("auto", 4);     8'd93: e = mk("pudef", 5);
      8'd94: e = mk("graphic", 7);  8'd95: e = mk("paint", 5);
      8'd96: e = mk("char", 4);     8'd97: e = mk("box", 3);
      8'd98: e = mk("circle", 6);   8'd99: e = mk("gshape", 6);
      8'd100: e = mk("sshape", 6);  8'd101: e = mk("draw", 4);
      8'd102: e = mk("locate", 6);  8'd103: e = mk("color", 5);
      8'd104: e = mk("scnclr", 6);  8'd105: e = mk("scale", 5);
      8'd106: e = mk("help", 4);    8'd107: e = mk("do", 2);
      8'd108: e = mk("loop", 4);    8'd109: e = mk("exit", 4);
      8'd110: e = mk("directory", 9); 8'd111: e = mk("dsave", 5);
      8'd112: e = mk("dload", 5);   8'd113: e = mk("header", 6);
      8'd114: e = mk("scratch", 7); 8'd115: e = mk("collect", 7);
      8'd116: e = mk("copy", 4);    8'd117: e = mk("rename", 6);
      8'd118: e = mk("backup", 6);  8'd119: e = mk("delete", 6);
      8'd120: e = mk("renumber", 8); 8'd121: e = mk("key", 3);
      8'd122: e = mk("monitor", 7); 8'd123: e = mk("using", 5);
      8'd124: e = mk("until", 5);   8'd125: e = mk("while", 5);
      // CE page
      8'd130: e = mk("pot", 3);     8'd131: e = mk("bump", 4);
      8'd132: e = mk("pen", 3);     8'd133: e = mk("rsppos", 6);
      8'd134: e = mk("rsprite", 7); 8'd135: e = mk("rspcolor", 8);
      8'd136: e = mk("xor", 3);     8'd137: e = mk("rwindow", 7);
      8'd138: e = mk("pointer", 7);
      // FE page
      8'd141: e = mk("bank", 4);    8'd142: e = mk("filter", 6);
      8'd143: e = mk("play", 4);    8'd144: e = mk("tempo", 5);
      8'd145: e = mk("movspr", 6);  8'd146: e = mk("sprite", 6);
      8'd147: e = mk("sprcolor", 8); 8'd148: e = mk("rreg", 4);
      8'd149: e = mk("envelope", 8); 8'd150: e = mk("sleep", 5);
      8'd151: e = mk("catalog", 7); 8'd152: e = mk("dopen", 5);
      8'd153: e = mk("append", 6);  8'd154: e = mk("dclose", 6);
      8'd155: e = mk("bsave", 5);   8'd156: e = mk("bload", 5);
      8'd157: e = mk("record", 6);  8'd158: e = mk("concat", 6);
      8'd159: e = mk("dverify", 7); 8'd160: e = mk("dclear", 6);
      8'd161: e = mk("sprsav", 6);  8'd162: e = mk("collision", 9);
      8'd163: e = mk("begin", 5);   8'd164: e = mk("bend", 4);
      8'd165: e = mk("window", 6);  8'd166: e = mk("boot", 4);
      8'd167: e = mk("width", 5);   8'd168: e = mk("sprdef", 6);
      8'd169: e = mk("quit", 4);    8'd170: e = mk("stash", 5);
      8'd172: e = mk("fetch", 5);
      8'd174: e = mk("swap", 4);    8'd175: e = mk("off", 3);
      8'd176: e = mk("fast", 4);    8'd177: e = mk("slow", 4);
      default: e = mk('0, 0);
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

@@ sv/bte_kw_rom.sv @@
// ----------------------------------------------------------------------------
// bte_kw_rom
// Keyword ROM with one registered read port; data holds when not enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_kw_rom import bte_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rd_en,
  input  wire logic [7:0] rd_addr,
  output kw_entry_t      rd_data
);

  kw_entry_t rom [KW_ENTRIES];

  always_comb begin
    for (int i = 0; i < KW_ENTRIES; i++) begin
      rom[i] = kw_lookup(8'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/basic_token_expander.sv @@
// ----------------------------------------------------------------------------
// basic_token_expander
// Expands tokenized BASIC line bytes into plain text characters.
// ----------------------------------------------------------------------------
// Each input byte is one transfer on s_axis. Plain, string and remark bytes
// give one character in the cycle after they are taken. A keyword token reads
// the keyword ROM (a registered read) and then emits one character per cycle
// while the output is not stalled, at most MAX_KEYWORD_CHARS characters. A
// prefix byte (0xCE/0xFE) gives no output; a zero byte gives a single
// line-end transfer and returns to normal mode. The last transfer caused by
// each input byte carries tlast. No new byte is taken while a keyword is
// being emitted.
`default_nettype none

module basic_token_expander import bte_pkg::*; #(
  parameter int MAX_KEYWORD_CHARS = 9
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] out_char
  output      logic       m_axis_tlast,   // last
  output      logic [1:0] m_axis_tuser    // [0] line_end, [1] unknown_token
);

  localparam int CNT_W = $clog2(MAX_KEYWORD_CHARS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_KW   = 1'b1;

  logic       state;
  logic [1:0] scan_mode;
  logic       pending_prefix;
  logic       prefix_is_fe;
  logic [CNT_W-1:0] char_idx;

  logic       out_free;
  logic       accept;
  logic       rom_en;
  logic [7:0] rom_addr;
  kw_entry_t  rom_data;
  logic [7:0] b;

  logic [CNT_W-1:0] eff_len;
  logic [KW_LEN_W-1:0] sel_pos;
  logic [7:0] kw_char;
  logic       kw_last;

  assign b             = s_axis_tdata;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Pick the ROM entry for a token; only meaningful when rom_en is set.
  always_comb begin
    rom_en   = 1'b0;
    rom_addr = EMPTY_IDX;
    if (accept && b != 8'd0) begin
      if (pending_prefix) begin
        rom_en = 1'b1;
        if (prefix_is_fe) begin
          rom_addr = (b < FE_COUNT) ? FE_BASE + b : EMPTY_IDX;
        end else begin
          rom_addr = (b < CE_COUNT) ? CE_BASE + b : EMPTY_IDX;
        end
      end else if (scan_mode != MODE_STRING && scan_mode != MODE_REMARK &&
                   b[7] && b != PREFIX_CE && b != PREFIX_FE) begin
        rom_en   = 1'b1;
        rom_addr = b & LOW_SEVEN;
      end
    end
  end

  bte_kw_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Cap the length at the parameter; characters count from the high end.
  always_comb begin
    if (32'(rom_data.len) > MAX_KEYWORD_CHARS) begin
      eff_len = CNT_W'(MAX_KEYWORD_CHARS);
    end else begin
      eff_len = CNT_W'(rom_data.len);
    end
    sel_pos = rom_data.len - KW_LEN_W'(1) - KW_LEN_W'(char_idx);
    kw_char = rom_data.text[sel_pos[3:0]*8 +: 8];
    kw_last = (char_idx == eff_len - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    logic tvalid_next;
    tvalid_next = m_axis_tvalid && !m_axis_tready;
    if (rst) begin
      state          <= ST_IDLE;
      scan_mode      <= MODE_NORMAL;
      pending_prefix <= 1'b0;
      prefix_is_fe   <= 1'b0;
      char_idx       <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            char_idx <= '0;
            if (b == 8'd0) begin
              // Line end: report a dangling prefix, drop back to normal.
              tvalid_next    = 1'b1;
              m_axis_tdata   <= 8'd0;
              m_axis_tlast   <= 1'b1;
              m_axis_tuser   <= {pending_prefix, 1'b1};
              scan_mode      <= MODE_NORMAL;
              pending_prefix <= 1'b0;
              prefix_is_fe   <= 1'b0;
            end else if (pending_prefix) begin
              pending_prefix <= 1'b0;
              state          <= ST_KW;
            end else if (scan_mode == MODE_STRING || scan_mode == MODE_REMARK) begin
              if (scan_mode == MODE_STRING && b == QUOTE) begin
                scan_mode <= MODE_NORMAL;
              end
              tvalid_next   = 1'b1;
              m_axis_tdata  <= fold_case(b);
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= 2'b00;
            end else if (b == QUOTE) begin
              scan_mode     <= MODE_STRING;
              tvalid_next   = 1'b1;
              m_axis_tdata  <= b;
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= 2'b00;
            end else if (b == PREFIX_CE || b == PREFIX_FE) begin
              // Hold the prefix for the next byte; nothing to emit.
              pending_prefix <= 1'b1;
              prefix_is_fe   <= (b == PREFIX_FE);
            end else if (b[7]) begin
              if (b == REM_TOKEN) begin
                scan_mode <= MODE_REMARK;
              end
              state <= ST_KW;
            end else begin
              tvalid_next   = 1'b1;
              m_axis_tdata  <= fold_case(b);
              m_axis_tlast  <= 1'b1;
              m_axis_tuser  <= 2'b00;
            end
          end
        end
        ST_KW: begin
          if (out_free) begin
            tvalid_next = 1'b1;
            if (eff_len == '0) begin
              // No keyword behind this code: flag it.
              m_axis_tdata <= 8'd0;
              m_axis_tlast <= 1'b1;
              m_axis_tuser <= 2'b10;
              state        <= ST_IDLE;
            end else begin
              m_axis_tdata <= kw_char;
              m_axis_tlast <= kw_last;
              m_axis_tuser <= 2'b00;
              char_idx     <= char_idx + CNT_W'(1);
              if (kw_last) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      m_axis_tvalid <= tvalid_next;
    end
  end

  // A prefix is only ever pending in normal mode.
  a_prefix_mode: assert property (@(posedge clk) disable iff (rst)
    pending_prefix |-> (scan_mode == MODE_NORMAL))
    else $error("prefix pending outside normal mode");

  // A zero byte leaves a clean normal-mode state behind.
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && b == 8'd0) |=> (scan_mode == MODE_NORMAL && !pending_prefix))
    else $error("line end did not reset mode");

  // A line-end transfer is always the final one for its byte.
  a_lend_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("line end without tlast");

  // A finished keyword returns the block to taking input.
  a_kw_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KW && out_free && (eff_len == '0 || kw_last)) |=> state == ST_IDLE)
    else $error("keyword emission did not finish");

endmodule

`default_nettype wire
